// File: rtl/agmt_pkg.sv
// Shared types, codes and the volume gain table of the audio gain, mute and trim stage.
package agmt_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] FUNC_BUF_START = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE    = 2'd1;
    localparam logic [1:0] FUNC_BUF_END   = 2'd2;

    // Clock trim codes.
    localparam logic [1:0] TRIM_SLOW   = 2'd0;
    localparam logic [1:0] TRIM_NORMAL = 2'd1;
    localparam logic [1:0] TRIM_FAST   = 2'd2;

    localparam logic [15:0] THRESHOLD_RESET   = 16'd4;
    localparam logic [16:0] GAIN_RESET        = 17'd983;
    localparam logic [11:0] LEVEL_COUNT_LIMIT = 12'd4093;
    localparam logic [6:0]  VOLUME_MAX        = 7'd100;
    localparam int          GAIN_STEP_SHIFT   = 6;

    localparam logic [16:0] GAIN_TABLE [0:100] = '{
        17'd0,     17'd4,     17'd8,     17'd12,    17'd16,
        17'd20,    17'd24,    17'd27,    17'd29,    17'd31,
        17'd34,    17'd37,    17'd40,    17'd44,    17'd48,
        17'd52,    17'd57,    17'd61,    17'd67,    17'd73,
        17'd79,    17'd86,    17'd94,    17'd102,   17'd111,
        17'd120,   17'd131,   17'd142,   17'd155,   17'd168,
        17'd183,   17'd199,   17'd217,   17'd236,   17'd256,
        17'd279,   17'd303,   17'd330,   17'd359,   17'd390,
        17'd424,   17'd462,   17'd502,   17'd546,   17'd594,
        17'd646,   17'd703,   17'd764,   17'd831,   17'd904,
        17'd983,   17'd1069,  17'd1163,  17'd1265,  17'd1376,
        17'd1496,  17'd1627,  17'd1770,  17'd1925,  17'd2094,
        17'd2277,  17'd2476,  17'd2693,  17'd2929,  17'd3186,
        17'd3465,  17'd3769,  17'd4099,  17'd4458,  17'd4849,
        17'd5274,  17'd5736,  17'd6239,  17'd6785,  17'd7380,
        17'd8026,  17'd8730,  17'd9495,  17'd10327, 17'd11232,
        17'd12216, 17'd13286, 17'd14450, 17'd15716, 17'd17093,
        17'd18591, 17'd20220, 17'd21992, 17'd23919, 17'd26015,
        17'd28294, 17'd30773, 17'd33470, 17'd36403, 17'd39592,
        17'd43061, 17'd46835, 17'd50938, 17'd55402, 17'd60256,
        17'd65536
    };

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] left_word;
        logic [31:0] right_word;
        logic [11:0] fifo_level;
        logic        rx_stable;
        logic [6:0]  volume_index;
    } agmt_in_t;

    typedef struct packed {
        logic signed [31:0] left_out;
        logic signed [31:0] right_out;
        logic [1:0]         clock_trim;
        logic               muted;
        logic               signal_present;
    } agmt_out_t;

endpackage

// File: rtl/audio_gain_mute_trim_core.sv
// Stereo playback stage: mute, clock trim, gain ramp, sample scaling and level detection.
// Every accepted beat produces exactly one result beat. The block takes one beat per
// clock cycle while the result side is not stalled; a result beat passes through the
// input register, then one pass of scaling and state update into the result register.
// Buffer-start beats update mute, trim and the gain ramp, sample beats scale both
// channels by the current gain unless muted, and buffer-end beats report whether the
// average absolute level exceeded level_threshold. The threshold comes through the
// always-ready cfg channel; write it only while no beat is in flight (not enforced).
module audio_gain_mute_trim_core #(
    parameter int FIFO_DEPTH = 2048,
    parameter int TRIM_BAND  = 384
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  agmt_pkg::agmt_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output agmt_pkg::agmt_out_t m_data
);

    localparam int HALF_LEVEL = FIFO_DEPTH / 2;
    localparam int LOW_LEVEL  = HALF_LEVEL - TRIM_BAND;
    localparam int HIGH_LEVEL = HALF_LEVEL + TRIM_BAND;
    localparam logic signed [17:0] HALF_C = 18'(HALF_LEVEL);
    localparam logic signed [17:0] LOW_C  = 18'(LOW_LEVEL);
    localparam logic signed [17:0] HIGH_C = 18'(HIGH_LEVEL);

    logic [15:0]         thr_reg;
    logic                in_vld_reg;
    agmt_pkg::agmt_in_t  in_reg;
    logic                out_vld_reg;
    agmt_pkg::agmt_out_t out_reg;
    logic [16:0]         gain_reg, gain_next;
    logic                mute_reg, mute_next;
    logic [1:0]          trim_reg, trim_next;
    logic [27:0]         sum_reg, sum_next;
    logic [11:0]         count_reg, count_next;
    agmt_pkg::agmt_out_t result;
    logic                advance;
    logic signed [17:0]  fifo_s;
    logic [6:0]          vidx;
    logic [16:0]         target;
    logic [17:0]         step;
    logic [16:0]         lvl_l, lvl_r;
    logic [28:0]         thr_prod;

    // Scales one 24-bit sample; the precision follows the gain magnitude and
    // the pre-divisions truncate toward zero.
    function automatic logic signed [31:0] scale_word(input logic [31:0] word,
                                                      input logic [16:0] g);
        logic signed [23:0] s;
        logic signed [23:0] a;
        logic [8:0]         m;
        logic signed [33:0] p;
        s = word[27:4];
        if (g >= 17'd256) begin
            a = s;
            m = g[16:8];
        end else if (g >= 17'd16) begin
            a = (s + (s[23] ? 24'sd15 : 24'sd0)) >>> 4;
            m = {5'd0, g[7:4]};
        end else begin
            a = (s + (s[23] ? 24'sd255 : 24'sd0)) >>> 8;
            m = {5'd0, g[3:0]};
        end
        p = 34'(a) * 34'($signed({1'b0, m}));
        p = p + 34'sd1;
        return p[31:0];
    endfunction

    function automatic logic [16:0] level_abs(input logic [31:0] word);
        logic signed [16:0] e;
        e = {word[27], word[27:12]};
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    assign cfg_ready     = 1'b1;
    assign advance       = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready       = !in_vld_reg || advance;
    assign m_valid       = out_vld_reg;
    assign m_data        = out_reg;

    assign fifo_s   = $signed({6'd0, in_reg.fifo_level});
    assign vidx     = (in_reg.volume_index > agmt_pkg::VOLUME_MAX) ?
                      agmt_pkg::VOLUME_MAX : in_reg.volume_index;
    assign target   = agmt_pkg::GAIN_TABLE[vidx];
    assign lvl_l    = level_abs(in_reg.left_word);
    assign lvl_r    = level_abs(in_reg.right_word);
    assign thr_prod = (29'(thr_reg) + 29'd1) * 29'(count_reg);

    always_comb begin
        gain_next  = gain_reg;
        mute_next  = mute_reg;
        trim_next  = trim_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        step       = '0;
        result.left_out       = 32'sd1;
        result.right_out      = 32'sd1;
        result.signal_present = 1'b0;
        case (in_reg.func)
            agmt_pkg::FUNC_BUF_START: begin
                if (!in_reg.rx_stable) begin
                    mute_next = 1'b1;
                end else if (mute_reg && fifo_s >= HALF_C) begin
                    mute_next = 1'b0;
                end
                sum_next   = '0;
                count_next = '0;
                if (!mute_next) begin
                    if (fifo_s <= LOW_C) begin
                        trim_next = agmt_pkg::TRIM_SLOW;
                    end else if (fifo_s <= HIGH_C) begin
                        trim_next = agmt_pkg::TRIM_NORMAL;
                    end else begin
                        trim_next = agmt_pkg::TRIM_FAST;
                    end
                    // Move one sixty-fourth of the distance, rounded down, plus one count.
                    if (gain_reg < target) begin
                        step      = ({1'b0, target - gain_reg} + 18'd64) >> agmt_pkg::GAIN_STEP_SHIFT;
                        gain_next = gain_reg + step[16:0];
                    end else if (gain_reg > target) begin
                        step      = ({1'b0, gain_reg - target} + 18'd64) >> agmt_pkg::GAIN_STEP_SHIFT;
                        gain_next = gain_reg - step[16:0];
                    end
                end
            end
            agmt_pkg::FUNC_SAMPLE: begin
                if (!mute_reg) begin
                    result.left_out  = scale_word(in_reg.left_word, gain_reg);
                    result.right_out = scale_word(in_reg.right_word, gain_reg);
                    if (count_reg <= agmt_pkg::LEVEL_COUNT_LIMIT) begin
                        sum_next   = sum_reg + {11'd0, lvl_l} + {11'd0, lvl_r};
                        count_next = count_reg + 12'd2;
                    end
                end
            end
            agmt_pkg::FUNC_BUF_END: begin
                result.signal_present = (count_reg != 12'd0) && ({1'b0, sum_reg} >= thr_prod);
                sum_next   = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
        result.clock_trim = trim_next;
        result.muted      = mute_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= agmt_pkg::THRESHOLD_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            gain_reg    <= agmt_pkg::GAIN_RESET;
            mute_reg    <= 1'b1;
            trim_reg    <= agmt_pkg::TRIM_NORMAL;
            sum_reg     <= '0;
            count_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                gain_reg    <= gain_next;
                mute_reg    <= mute_next;
                trim_reg    <= trim_next;
                sum_reg     <= sum_next;
                count_reg   <= count_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

endmodule

// File: rtl/agmt_checker.sv
// Port-level checks for the audio gain, mute and trim stage, bound to its top level.
module agmt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input agmt_pkg::agmt_out_t m_data
);

    // No result beat may be offered right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // While muted the DAC sees the zero code on both channels.
    a_mute_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.muted |-> m_data.left_out == 32'sd1 && m_data.right_out == 32'sd1)
        else $error("muted beat carries audio");

    // A level verdict only comes with a buffer-end beat, which carries no audio.
    a_verdict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.signal_present |->
            m_data.left_out == 32'sd1 && m_data.right_out == 32'sd1)
        else $error("level verdict on a sample beat");

endmodule

bind audio_gain_mute_trim_core agmt_checker u_agmt_checker (.*);
